FILE: hw/rtl/cnp_pkg.sv
// cnp_pkg: shared types and constants for the cpio newc entry parser.
// Holds the parse state and result structs, phase/kind codes and header constants.
// No dependencies.
`default_nettype none

package cnp_pkg;

    // phase codes double as byte kind codes
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_NAME     = 3'd1;
    localparam logic [2:0] PH_NAME_PAD = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_DATA_PAD = 3'd4;
    localparam logic [2:0] PH_END      = 3'd5;
    localparam logic [2:0] PH_ERROR    = 3'd6;

    localparam logic [6:0] HEADER_BYTES = 7'd110;
    localparam logic [6:0] MAGIC_BYTES  = 7'd6;
    localparam logic [3:0] TRAILER_LEN  = 4'd10;
    localparam logic [3:0] TRAILER_TERM = 4'd11;

    localparam logic [3:0] FIELD_FILESIZE = 4'd6;
    localparam logic [3:0] FIELD_NAMESIZE = 4'd11;

    localparam logic [7:0] MAGIC_TEXT [0:5] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};
    localparam logic [7:0] TRAILER_TEXT [0:9] = '{
        8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
    };

    typedef struct packed {
        logic [2:0]  phase;
        logic [6:0]  hpos;
        logic [31:0] acc;
        logic [31:0] name_len;
        logic [31:0] file_len;
        logic [31:0] remaining;
        logic [1:0]  offset;
        logic [3:0]  trl_idx;
        logic        trl_miss;
    } t_state;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_out;
        logic        field_done;
        logic [3:0]  field_index;
        logic [31:0] field_value;
        logic        entry_is_trailer;
        logic        entry_done;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/cnp_step.sv
// cnp_step: next-state and result logic for one archive byte.
// Pure combinational; uses cnp_pkg for state/result types and constants.
`default_nettype none

module cnp_step import cnp_pkg::*; (
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    localparam logic [1:0] LVL_NAME     = 2'd0;
    localparam logic [1:0] LVL_NAME_PAD = 2'd1;
    localparam logic [1:0] LVL_DATA     = 2'd2;
    localparam logic [1:0] LVL_DATA_PAD = 2'd3;

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    t_state      s;
    t_state      n;
    t_result     res;
    logic        enter;
    logic [1:0]  lvl;
    logic        bad;
    logic [4:0]  hex;
    logic [6:0]  fpos;
    logic [31:0] acc_new;
    logic [31:0] rem_dec;
    logic [3:0]  m_idx;
    logic        m_miss;

    always_comb begin
        s = i_state;
        if (i_start) begin
            s = '0;
            s.phase = PH_HEADER;
        end
        n = s;
        n.offset = s.offset + 2'd1;

        res = '0;
        res.byte_out = i_byte;
        res.byte_kind = PH_ERROR;
        enter = 1'b0;
        lvl = LVL_NAME;
        bad = 1'b0;
        hex = hex_digit(i_byte);
        fpos = s.hpos - MAGIC_BYTES;
        acc_new = {s.acc[27:0], hex[3:0]};
        rem_dec = (s.remaining != 32'd0) ? s.remaining - 32'd1 : s.remaining;

        // trailer name compare, one character per name byte
        m_idx = s.trl_idx;
        m_miss = s.trl_miss;
        if (!s.trl_miss && s.trl_idx <= TRAILER_LEN) begin
            if (s.trl_idx < TRAILER_LEN) begin
                if (i_byte == TRAILER_TEXT[s.trl_idx]) begin
                    m_idx = s.trl_idx + 4'd1;
                end else begin
                    m_miss = 1'b1;
                end
            end else begin
                if (i_byte == 8'h00) begin
                    m_idx = TRAILER_TERM;
                end else begin
                    m_miss = 1'b1;
                end
            end
        end

        unique case (s.phase)
            PH_HEADER: begin
                res.byte_kind = PH_HEADER;
                if (s.hpos < MAGIC_BYTES) begin
                    bad = (i_byte != MAGIC_TEXT[s.hpos[2:0]]);
                end else if (s.hpos < HEADER_BYTES) begin
                    if (!hex[4]) begin
                        bad = 1'b1;
                    end else begin
                        n.acc = acc_new;
                        if (fpos[2:0] == 3'd7) begin
                            res.field_done = 1'b1;
                            res.field_index = fpos[6:3];
                            res.field_value = acc_new;
                            if (fpos[6:3] == FIELD_FILESIZE) begin
                                n.file_len = acc_new;
                            end
                            if (fpos[6:3] == FIELD_NAMESIZE) begin
                                n.name_len = acc_new;
                            end
                            n.acc = 32'd0;
                        end
                    end
                end else begin
                    bad = 1'b1;
                end
                if (bad) begin
                    n.phase = PH_ERROR;
                    res.byte_kind = PH_ERROR;
                    res.field_done = 1'b0;
                    res.field_index = 4'd0;
                    res.field_value = 32'd0;
                end else if (s.hpos == HEADER_BYTES - 7'd1) begin
                    enter = 1'b1;
                    lvl = LVL_NAME;
                end else begin
                    n.hpos = s.hpos + 7'd1;
                end
            end
            PH_NAME: begin
                res.byte_kind = PH_NAME;
                n.trl_idx = m_idx;
                n.trl_miss = m_miss;
                n.remaining = rem_dec;
                if (rem_dec == 32'd0) begin
                    res.entry_is_trailer = !m_miss && (m_idx >= TRAILER_LEN);
                    enter = 1'b1;
                    lvl = LVL_NAME_PAD;
                end
            end
            PH_NAME_PAD: begin
                res.byte_kind = PH_NAME_PAD;
                res.entry_is_trailer = !s.trl_miss && (s.trl_idx >= TRAILER_LEN);
                if (n.offset == 2'd0) begin
                    enter = 1'b1;
                    lvl = LVL_DATA;
                end
            end
            PH_DATA: begin
                res.byte_kind = PH_DATA;
                res.entry_is_trailer = !s.trl_miss && (s.trl_idx >= TRAILER_LEN);
                n.remaining = rem_dec;
                if (rem_dec == 32'd0) begin
                    enter = 1'b1;
                    lvl = LVL_DATA_PAD;
                end
            end
            PH_DATA_PAD: begin
                res.byte_kind = PH_DATA_PAD;
                res.entry_is_trailer = !s.trl_miss && (s.trl_idx >= TRAILER_LEN);
                enter = 1'b1;
                lvl = LVL_DATA_PAD;
            end
            PH_END: begin
                res.byte_kind = PH_END;
            end
            default: begin
                res.byte_kind = PH_ERROR;
                n.phase = PH_ERROR;
            end
        endcase

        // phase transition chain: zero lengths and aligned offsets fall through
        if (enter) begin
            if (lvl == LVL_NAME && n.name_len != 32'd0) begin
                n.phase = PH_NAME;
                n.remaining = n.name_len;
            end else if (lvl <= LVL_NAME_PAD && n.offset != 2'd0) begin
                n.phase = PH_NAME_PAD;
            end else if (lvl <= LVL_DATA && n.file_len != 32'd0) begin
                n.phase = PH_DATA;
                n.remaining = n.file_len;
            end else if (n.offset != 2'd0) begin
                n.phase = PH_DATA_PAD;
            end else begin
                res.entry_done = 1'b1;
                if (!n.trl_miss && n.trl_idx >= TRAILER_LEN) begin
                    n.phase = PH_END;
                end else begin
                    n.phase = PH_HEADER;
                    n.hpos = 7'd0;
                    n.acc = 32'd0;
                    n.trl_idx = 4'd0;
                    n.trl_miss = 1'b0;
                end
            end
        end

        o_state = n;
        o_result = res;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cnp_out_reg.sv
// cnp_out_reg: result register with valid/ready toward the receiver.
// Uses cnp_pkg for the result struct.
`default_nettype none

module cnp_out_reg import cnp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/cpio_newc_entry_parser.sv
// cpio_newc_entry_parser: classifies a cpio newc archive stream byte by byte.
// Uses cnp_pkg, cnp_step (per-byte logic) and cnp_out_reg (result register).
//
// Input channel: i_in_valid / o_in_ready carry one archive byte per request,
// with i_start_archive set on the first byte of a new archive.
// Output channel: o_out_valid / i_out_ready carry one result per input byte:
// byte kind, the byte itself, header field completion (index and value),
// trailer flag and end-of-entry flag.
// Each byte waits in the input register, then the per-byte logic loads its result
// into the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse state updates
// as a byte moves from the input register into the result register.
// Reset: i_rst_n low clears both pipeline valids and the parse state to
// header phase at archive offset zero.
// Stall: while i_out_ready is low a held result blocks the input register;
// o_in_ready drops once the input register is also full, and no request is
// dropped or repeated.
`default_nettype none

module cpio_newc_entry_parser import cnp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_archive,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_byte_kind,
    output logic [7:0]  o_byte_out,
    output logic        o_field_done,
    output logic [3:0]  o_field_index,
    output logic [31:0] o_field_value,
    output logic        o_entry_is_trailer,
    output logic        o_entry_done
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    t_state     r_state;
    t_state     n_state;
    t_result    step_res;
    t_result    out_res;
    logic       s1_fire;
    logic       in_fire;

    assign s1_fire    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_archive;
        end
    end

    cnp_step u_step (
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // all-zero state is header phase at offset zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    cnp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_fire),
        .i_data  (step_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (out_res)
    );

    assign o_byte_kind        = out_res.byte_kind;
    assign o_byte_out         = out_res.byte_out;
    assign o_field_done       = out_res.field_done;
    assign o_field_index      = out_res.field_index;
    assign o_field_value      = out_res.field_value;
    assign o_entry_is_trailer = out_res.entry_is_trailer;
    assign o_entry_done       = out_res.entry_done;

`ifndef ASSERT_OFF
    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out_valid && !i_out_ready |=> r_in_valid && o_out_valid)
        else $error("input register lost a request while output stalled");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_in_start && r_state.phase == PH_ERROR |=> r_state.phase == PH_ERROR)
        else $error("error phase left without restart");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_in_start && r_state.phase == PH_END |=> r_state.phase == PH_END)
        else $error("after-end phase left without restart");

    a_hpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_HEADER |-> r_state.hpos < HEADER_BYTES)
        else $error("header position out of range");

    a_field_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_done |-> o_byte_kind == PH_HEADER && o_field_index <= 4'd12)
        else $error("field completion outside header");
`endif

endmodule

`default_nettype wire
